>>> rtl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// shared types, constants and helpers for the page frame free list allocator
// ----------------------------------------------------------------------------
package pfa_pkg;

   localparam int NUM_FRAMES_MAX = 64;
   localparam int FRAME_W        = $clog2(NUM_FRAMES_MAX);
   localparam int NFRAMES_W      = $clog2(NUM_FRAMES_MAX + 1);
   localparam int LINK_DEPTH     = NUM_FRAMES_MAX;
   localparam int STATUS_W       = 2;

   localparam logic [NFRAMES_W-1:0] NFRAMES_MIN = NFRAMES_W'(2);
   localparam logic [NFRAMES_W-1:0] NFRAMES_TOP = NFRAMES_W'(NUM_FRAMES_MAX);

   // operation codes
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_GRANT   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOFRAME = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_UNUSED  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic latch;       // take the accepted request beat
      logic emit_single; // apply a free or a one-beat answer
      logic issue_read;  // read the link of the head frame
      logic do_pop;      // pop the head frame and emit it
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_single;   // item answers with one beat and no pop
      logic last_pop;    // one frame left to pop
      logic out_free;    // result register can take a beat
   } status_type;

   // link value of a frame straight after the list was rebuilt
   function automatic logic [FRAME_W-1:0] link_default(
      input logic [FRAME_W-1:0]   frame,
      input logic [NFRAMES_W-1:0] nframes
   );
      logic [NFRAMES_W-1:0] nxt;
      nxt = {1'b0, frame} + NFRAMES_W'(1);
      if ((frame != '0) && (nxt < nframes)) begin
         return nxt[FRAME_W-1:0];
      end
      return '0;
   endfunction

endpackage

>>> rtl/pfa_if.sv
// ----------------------------------------------------------------------------
// pfa_if
// valid/ready channels for allocator requests and responses
// ----------------------------------------------------------------------------
interface pfa_req_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [pfa_pkg::FRAME_W-1:0] count;
   logic [pfa_pkg::FRAME_W-1:0] freed_frame;

   modport source (output valid, output kind, output count, output freed_frame,
                   input ready);
   modport sink   (input valid, input kind, input count, input freed_frame,
                   output ready);
endinterface

interface pfa_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pfa_pkg::STATUS_W-1:0] status;
   logic [pfa_pkg::FRAME_W-1:0]  granted_frame;
   logic                         last;
   logic [pfa_pkg::FRAME_W-1:0]  free_count;

   modport source (output valid, output status, output granted_frame,
                   output last, output free_count, input ready);
   modport sink   (input valid, input status, input granted_frame,
                   input last, input free_count, output ready);
endinterface

>>> rtl/pfa_ram.sv
// ----------------------------------------------------------------------------
// pfa_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module pfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/pfa_ctrl.sv
// ----------------------------------------------------------------------------
// pfa_ctrl
// sequencer for request intake, single-beat answers and frame pops
// ----------------------------------------------------------------------------
module pfa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pfa_pkg::status_type stat,
   output pfa_pkg::cmd_type    cmd
);

   pfa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         pfa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = pfa_pkg::ST_EXEC;
            end
         end
         pfa_pkg::ST_EXEC: begin
            if (stat.is_single) begin
               if (stat.out_free) begin
                  cmd.emit_single = 1'b1;
                  state_in        = pfa_pkg::ST_IDLE;
               end
            end else begin
               cmd.issue_read = 1'b1;
               state_in       = pfa_pkg::ST_POP;
            end
         end
         pfa_pkg::ST_POP: begin
            if (stat.out_free) begin
               cmd.do_pop = 1'b1;
               state_in   = stat.last_pop ? pfa_pkg::ST_IDLE : pfa_pkg::ST_EXEC;
            end
         end
         default: begin
            state_in = pfa_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/pfa_dpath.sv
// ----------------------------------------------------------------------------
// pfa_dpath
// free list state, link memory and response register
// ----------------------------------------------------------------------------
module pfa_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [pfa_pkg::NFRAMES_W-1:0]  csr_wdata,
   input  logic                           req_kind,
   input  logic [pfa_pkg::FRAME_W-1:0]    req_count,
   input  logic [pfa_pkg::FRAME_W-1:0]    req_freed_frame,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [pfa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [pfa_pkg::FRAME_W-1:0]    rsp_granted_frame,
   output logic                           rsp_last,
   output logic [pfa_pkg::FRAME_W-1:0]    rsp_free_count,
   input  pfa_pkg::cmd_type               cmd,
   output pfa_pkg::status_type            stat
);

   localparam int FW = pfa_pkg::FRAME_W;
   localparam int NW = pfa_pkg::NFRAMES_W;

   // list state
   logic [NW-1:0]                  nframes_ff, nframes_in;
   logic [FW-1:0]                  head_ff, head_in;
   logic [FW-1:0]                  nfree_ff, nfree_in;
   logic [pfa_pkg::LINK_DEPTH-1:0] written_ff, written_in;

   // held item
   logic          kind_ff;
   logic [FW-1:0] remain_ff, remain_in;
   logic [FW-1:0] freed_ff;

   // pending link read
   logic          rd_written_ff;
   logic [FW-1:0] rd_frame_ff;
   logic [FW-1:0] rd_default_ff;
   logic [FW-1:0] ram_rdata;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [pfa_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [FW-1:0]                frame_ff, frame_in;
   logic                         last_ff, last_in;
   logic [FW-1:0]                fcount_ff, fcount_in;

   logic          free_bad;
   logic          alloc_over;
   logic          free_ok;
   logic [FW-1:0] link_val;
   logic [NW-1:0] csr_sat;

   assign free_bad = (freed_ff == '0) || ({1'b0, freed_ff} >= nframes_ff)
                  || ({1'b0, nfree_ff} >= (nframes_ff - NW'(1)));
   assign alloc_over = remain_ff > nfree_ff;
   assign free_ok    = (kind_ff == pfa_pkg::KIND_FREE) && !free_bad;
   assign link_val   = rd_written_ff ? ram_rdata : rd_default_ff;

   always_comb begin
      if (csr_wdata < pfa_pkg::NFRAMES_MIN) begin
         csr_sat = pfa_pkg::NFRAMES_MIN;
      end else if (csr_wdata > pfa_pkg::NFRAMES_TOP) begin
         csr_sat = pfa_pkg::NFRAMES_TOP;
      end else begin
         csr_sat = csr_wdata;
      end
   end

   assign stat.is_single = (kind_ff == pfa_pkg::KIND_FREE) || (remain_ff == '0)
                        || alloc_over;
   assign stat.last_pop  = remain_ff == FW'(1);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   pfa_ram #(
      .WIDTH (FW),
      .DEPTH (pfa_pkg::LINK_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (cmd.emit_single && free_ok),
      .wr_addr (freed_ff),
      .wr_data (head_ff),
      .rd_en   (cmd.issue_read),
      .rd_addr (head_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      nframes_in   = nframes_ff;
      head_in      = head_ff;
      nfree_in     = nfree_ff;
      written_in   = written_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      frame_in     = frame_ff;
      last_in      = last_ff;
      fcount_in    = fcount_ff;

      if (csr_we) begin
         nframes_in = csr_sat;
         head_in    = FW'(1);
         nfree_in   = FW'(csr_sat - NW'(1));
         written_in = '0;
      end

      if (cmd.latch) begin
         remain_in = req_count;
      end

      if (cmd.emit_single) begin
         rsp_valid_in = 1'b1;
         frame_in     = '0;
         last_in      = 1'b1;
         fcount_in    = nfree_ff;
         if (kind_ff == pfa_pkg::KIND_FREE) begin
            if (free_bad) begin
               status_in = pfa_pkg::STATUS_REFUSED;
            end else begin
               status_in            = pfa_pkg::STATUS_NOFRAME;
               head_in              = freed_ff;
               nfree_in             = nfree_ff + FW'(1);
               fcount_in            = nfree_ff + FW'(1);
               written_in[freed_ff] = 1'b1;
            end
         end else if (alloc_over) begin
            status_in = pfa_pkg::STATUS_REFUSED;
         end else begin
            status_in = pfa_pkg::STATUS_NOFRAME;
         end
      end

      if (cmd.do_pop) begin
         rsp_valid_in = 1'b1;
         status_in    = pfa_pkg::STATUS_GRANT;
         frame_in     = rd_frame_ff;
         last_in      = remain_ff == FW'(1);
         fcount_in    = nfree_ff - FW'(1);
         head_in      = link_val;
         nfree_in     = nfree_ff - FW'(1);
         remain_in    = remain_ff - FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nframes_ff   <= pfa_pkg::NFRAMES_TOP;
         head_ff      <= FW'(1);
         nfree_ff     <= FW'(pfa_pkg::NFRAMES_TOP - NW'(1));
         written_ff   <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         nframes_ff   <= nframes_in;
         head_ff      <= head_in;
         nfree_ff     <= nfree_in;
         written_ff   <= written_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff  <= req_kind;
         freed_ff <= req_freed_frame;
      end
      if (cmd.issue_read) begin
         rd_frame_ff   <= head_ff;
         rd_written_ff <= written_ff[head_ff];
         rd_default_ff <= pfa_pkg::link_default(head_ff, nframes_ff);
      end
      status_ff <= status_in;
      frame_ff  <= frame_in;
      last_ff   <= last_in;
      fcount_ff <= fcount_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_granted_frame = frame_ff;
   assign rsp_last          = last_ff;
   assign rsp_free_count    = fcount_ff;

endmodule

>>> rtl/page_frame_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// page_frame_free_list_allocator_top
// page frame allocator over a linked free list of frame numbers
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake        payload
//  req_bus   in   valid / ready    kind, count, freed_frame
//  rsp_bus   out  valid / ready    status, granted_frame, last, free_count
//  csr_*     in   csr_we           csr_wdata (num_frames, 7 bits)
//
//  a free item, a refused item or an empty allocation answers with one beat,
//  an allocation pops its frames one by one: each pop waits on the
//  registered read of the link ram before the head can move on
//  reset restores 64 frames with frames 1..63 linked in order; a csr write
//  rebuilds the list at once by clearing the per-frame written flags
//  a stalled response beat holds the sequencer in place until it is taken
//
module page_frame_free_list_allocator_top (
   input  logic                          clock,
   input  logic                          reset,
   pfa_req_if.sink                       req_bus,
   pfa_rsp_if.source                     rsp_bus,
   input  logic                          csr_we,
   input  logic [pfa_pkg::NFRAMES_W-1:0] csr_wdata
);

   // command and status between sequencer and datapath
   pfa_pkg::cmd_type    cmd;
   pfa_pkg::status_type stat;

   // the sequencer owns request intake and decides each step
   pfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // the datapath holds list state, the link ram and the response register
   pfa_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_kind          (req_bus.kind),
      .req_count         (req_bus.count),
      .req_freed_frame   (req_bus.freed_frame),
      .rsp_ready         (rsp_bus.ready),
      .rsp_valid         (rsp_bus.valid),
      .rsp_status        (rsp_bus.status),
      .rsp_granted_frame (rsp_bus.granted_frame),
      .rsp_last          (rsp_bus.last),
      .rsp_free_count    (rsp_bus.free_count),
      .cmd               (cmd),
      .stat              (stat)
   );

endmodule

>>> rtl/pfa_checker.sv
// ----------------------------------------------------------------------------
// pfa_checker
// port-level checks on allocator responses
// ----------------------------------------------------------------------------
module pfa_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [pfa_pkg::STATUS_W-1:0] rsp_status,
   input logic [pfa_pkg::FRAME_W-1:0]  rsp_granted_frame,
   input logic                         rsp_last,
   input logic [pfa_pkg::FRAME_W-1:0]  rsp_free_count
);

   // answers without a frame always close the item
   a_nogrant_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != pfa_pkg::STATUS_GRANT) |-> rsp_last && rsp_granted_frame == '0)
   else $error("non-grant beat without last or with a frame");

   // frame 0 is the end marker and is never handed out
   a_grant_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == pfa_pkg::STATUS_GRANT) |-> rsp_granted_frame != '0)
   else $error("granted the reserved frame");

   // a grant that is not last is followed by another grant with one fewer free
   a_grant_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_status == pfa_pkg::STATUS_GRANT) && !rsp_last
      ##1 rsp_valid |-> rsp_status == pfa_pkg::STATUS_GRANT
                        && rsp_free_count == $past(rsp_free_count) - pfa_pkg::FRAME_W'(1))
   else $error("broken grant sequence");

   // a stalled beat stays put
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                 && $stable(rsp_granted_frame) && $stable(rsp_last)
                                 && $stable(rsp_free_count))
   else $error("response beat changed while stalled");

endmodule

bind page_frame_free_list_allocator_top pfa_checker u_pfa_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_status        (rsp_bus.status),
   .rsp_granted_frame (rsp_bus.granted_frame),
   .rsp_last          (rsp_bus.last),
   .rsp_free_count    (rsp_bus.free_count)
);
